@@ hw/rtl/bmpd_pkg.sv @@
// Shared types and constants of the BMP pixel-data decoder.
// No dependencies; imported by the decoder top level.
package bmpd_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int MAX_HEIGHT  = 4096;
	localparam int PAL_ENTRIES = 256;
	localparam int DIM_W       = 13;
	localparam int RUN_W       = 20;
	localparam int PAL_AW      = 8;
	localparam int RGB_W       = 24;

	// register indexes on the configuration port
	localparam logic [1:0] REG_DEPTH  = 2'd0;
	localparam logic [1:0] REG_MODE   = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;
	localparam logic [1:0] REG_HEIGHT = 2'd3;

	localparam logic [1:0] DEPTH_1  = 2'd0;
	localparam logic [1:0] DEPTH_4  = 2'd1;
	localparam logic [1:0] DEPTH_8  = 2'd2;
	localparam logic [1:0] DEPTH_24 = 2'd3;

	localparam logic [1:0] MODE_RLE8 = 2'd1;
	localparam logic [1:0] MODE_RLE4 = 2'd2;

	localparam logic CMD_PAL  = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	localparam logic [7:0] ESC_EOL   = 8'd0;
	localparam logic [7:0] ESC_EOI   = 8'd1;
	localparam logic [7:0] ESC_DELTA = 8'd2;

	typedef struct packed {
		logic       cmd;
		logic [7:0] palette_index;
		logic [7:0] palette_red;
		logic [7:0] palette_green;
		logic [7:0] palette_blue;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [RUN_W-1:0] run_length;
		logic             last;
		logic             image_done;
	} out_item_t;

endpackage

@@ hw/rtl/bmpd_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module bmpd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a_q <= mem_q[raddr_a];
			rdata_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;
endmodule

@@ hw/rtl/bmp_pixel_data_decoder.sv @@
// BMP pixel-data decoder top level: decode state, palette RAM, run merge, output buffer.
// Depends on bmpd_pkg and bmpd_ram.
//
// Load the palette with palette-write beats (cmd 0), set depth, compression, width and
// height on the APB port (any write restarts decoding and keeps the palette), then
// stream pixel-data bytes (cmd 1). Each data beat yields zero to eight output beats,
// each an RGB colour and a run length; adjacent equal colours from one input beat are
// merged, last marks the final beat of an input beat and image_done marks the beat
// that completes the image or reports end-of-image. Rows come bottom row first.
// Rate: one input beat per cycle when it yields at most one output beat and out_stall
// is low; a beat that yields several runs holds the input while the output buffer
// drains. Palette lookups go through a two-port RAM read in the cycle after
// acceptance; stage 1 then loads the merged runs into the output buffer. A run or
// delta that crosses a row end more than once (narrow images) engages a 13-step
// restoring divider for the column/row update, which holds the input while it runs.
// A two-colour RLE4 run emits up to eight pixels per beat; the beats presented
// meanwhile are consumed without effect and must be resent. End-of-line fills the
// row with palette entry 0; delta emits dx + dy*width pixels of palette entry 0.
module bmp_pixel_data_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bmpd_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output bmpd_pkg::out_item_t out_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import bmpd_pkg::*;

	typedef enum logic [3:0] {
		PH_START, PH_COLOUR, PH_ESC, PH_DX, PH_DY,
		PH_ABS, PH_ABSPAD, PH_ROWPAD, PH_DRAIN, PH_DONE
	} phase_t;

	typedef enum logic [1:0] {K_NONE, K_RUN, K_PAT, K_EOI} kind_t;

	// configuration
	logic [1:0]       depth_q, mode_q;
	logic [DIM_W-1:0] width_q, height_q;
	logic             cfg_we;
	logic [DIM_W-1:0] eff_w, eff_h;
	logic             rle8, rle4;

	// decode state
	phase_t           phase_q;
	logic [7:0]       run_rem_q, run_col_q, dcol_q;
	logic             nib_q;
	logic [1:0]       pad_q, slot_q;
	logic [15:0]      pbuf_q;
	logic [DIM_W-1:0] col_q, rows_q;

	// divider for multi-row position updates
	logic             div_busy_q;
	logic [3:0]       div_cnt_q;
	logic [DIM_W-1:0] div_rem_q;
	logic [2*DIM_W-1:0] div_shift;
	logic             div_ge;
	logic [DIM_W-1:0] div_rem_nx;

	// decode outputs
	kind_t            d_kind;
	logic [7:0]       d_idx_a, d_idx_b, d_dy;
	logic             d_direct, d_delta, d_raw, d_nib_tog;
	logic [RGB_W-1:0] d_rgb;
	logic [20:0]      d_n;
	logic [7:0]       d_sel;
	logic [3:0]       d_k, drain_k;
	logic [1:0]       d_rawpad;
	phase_t           n_phase;
	logic [7:0]       n_run_rem, n_run_col, n_dcol;
	logic             n_nib;
	logic [1:0]       n_pad, n_slot;
	logic [15:0]      n_pbuf;
	logic [7:0]       byte_v;
	logic [3:0]       hi, lo;
	logic [DIM_W-1:0] w_rem;
	logic [1:0]       rb2;

	// clip and position
	logic [2*DIM_W-1:0] left;
	logic [20:0]      p_n, n_eff;
	logic             is_put, done_now;
	logic [DIM_W-1:0] pos_add, rows_base;
	logic [DIM_W:0]   total;

	// handshake
	logic             in_acc, proc, pal_we, has_res;
	logic             buf_free, s1_adv, out_take, out_last;

	// stage 1 plan
	logic             s1_valid_q;
	kind_t            s1_kind;
	logic [RUN_W-1:0] s1_len;
	logic [3:0]       s1_k;
	logic [7:0]       s1_sel;
	logic             s1_direct, s1_done, s1_blk_a, s1_blk_b;
	logic [RGB_W-1:0] s1_rgb;
	logic [RGB_W-1:0] rd_a, rd_b, rgb_a, rgb_b;

	// merge
	logic [3:0]       m_cnt;
	logic [RGB_W-1:0] m_rgb [8];
	logic [RUN_W-1:0] m_len [8];

	// output buffer
	logic [RGB_W-1:0] buf_rgb_q [8];
	logic [RUN_W-1:0] buf_len_q [8];
	logic [3:0]       buf_cnt_q;
	logic [2:0]       buf_idx_q;
	logic             buf_done_q;

	//------------------------------------------------------------------
	// Configuration port
	//------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_DEPTH:  prdata = {30'd0, depth_q};
			REG_MODE:   prdata = {30'd0, mode_q};
			REG_WIDTH:  prdata = {19'd0, width_q};
			REG_HEIGHT: prdata = {19'd0, height_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= DEPTH_24;
			mode_q   <= 2'd0;
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_DEPTH:  depth_q  <= pwdata[1:0];
				REG_MODE:   mode_q   <= pwdata[1:0];
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default:    depth_q  <= depth_q;
			endcase
		end
	end

	// clamp dimensions into 1..MAX
	assign eff_w = (width_q == '0) ? DIM_W'(1) :
		(width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
	assign eff_h = (height_q == '0) ? DIM_W'(1) :
		(height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
	assign rle8 = (mode_q == MODE_RLE8) && (depth_q == DEPTH_8);
	assign rle4 = (mode_q == MODE_RLE4) && (depth_q == DEPTH_4);

	//------------------------------------------------------------------
	// Input handshake
	//------------------------------------------------------------------
	assign out_valid = (buf_cnt_q != 4'd0);
	assign out_last  = ({1'b0, buf_idx_q} == (buf_cnt_q - 4'd1));
	assign out_take  = out_valid && !out_stall;
	assign buf_free  = (buf_cnt_q == 4'd0) || (out_take && out_last);
	assign s1_adv    = s1_valid_q && buf_free;
	// hold input while dividing or while stage 1 cannot move on
	assign in_stall  = div_busy_q || (s1_valid_q && !buf_free);
	assign in_acc    = in_valid && !in_stall;
	// a beat that arrives during a pending two-colour run only drains that run
	assign proc   = in_acc && ((phase_q == PH_DRAIN) ||
		((in_item.cmd == CMD_DATA) && (phase_q != PH_DONE)));
	assign pal_we = in_acc && (in_item.cmd == CMD_PAL) && (phase_q != PH_DRAIN) &&
		({1'b0, in_item.palette_index} < 9'(PAL_ENTRIES));

	//------------------------------------------------------------------
	// Decode of one data beat against the current phase
	//------------------------------------------------------------------
	assign byte_v  = in_item.data_byte;
	assign hi      = byte_v[7:4];
	assign lo      = byte_v[3:0];
	assign w_rem   = eff_w - col_q;
	assign drain_k = (run_rem_q > 8'd8) ? 4'd8 : run_rem_q[3:0];

	always_comb begin
		case (depth_q)
			DEPTH_1:  rb2 = 2'(({1'b0, eff_w} + 14'd7) >> 3);
			DEPTH_4:  rb2 = 2'(({1'b0, eff_w} + 14'd1) >> 1);
			DEPTH_8:  rb2 = eff_w[1:0];
			default:  rb2 = 2'(eff_w[1:0] + {eff_w[0], 1'b0});
		endcase
	end

	always_comb begin
		d_kind    = K_NONE;
		d_idx_a   = '0;
		d_idx_b   = '0;
		d_direct  = 1'b0;
		d_rgb     = '0;
		d_n       = '0;
		d_sel     = '0;
		d_k       = 4'd1;
		d_delta   = 1'b0;
		d_dy      = '0;
		d_raw     = 1'b0;
		d_rawpad  = 2'(2'd0 - rb2);
		d_nib_tog = 1'b0;
		n_phase   = phase_q;
		n_run_rem = run_rem_q;
		n_run_col = run_col_q;
		n_nib     = nib_q;
		n_dcol    = dcol_q;
		n_pad     = pad_q;
		n_pbuf    = pbuf_q;
		n_slot    = slot_q;
		case (phase_q)
			PH_DRAIN: begin
				d_kind    = K_PAT;
				d_idx_a   = {4'd0, run_col_q[7:4]};
				d_idx_b   = {4'd0, run_col_q[3:0]};
				d_sel     = nib_q ? 8'h55 : 8'hAA;
				d_k       = drain_k;
				d_nib_tog = 1'b1;
				n_run_rem = run_rem_q - {4'd0, drain_k};
				n_phase   = (n_run_rem == 8'd0) ? PH_START : PH_DRAIN;
			end
			PH_ROWPAD: begin
				if (pad_q != 2'd0) begin
					n_pad = pad_q - 2'd1;
				end
				if (n_pad == 2'd0) begin
					n_phase = PH_START;
				end
			end
			PH_COLOUR: begin
				if (rle4 && (hi != lo)) begin
					// two-colour run, alternate nibbles from the high one
					d_kind    = K_PAT;
					d_idx_a   = {4'd0, hi};
					d_idx_b   = {4'd0, lo};
					d_sel     = 8'hAA;
					d_k       = drain_k;
					d_nib_tog = 1'b1;
					n_run_col = byte_v;
					n_nib     = 1'b0;
					n_run_rem = run_rem_q - {4'd0, drain_k};
					n_phase   = (n_run_rem == 8'd0) ? PH_START : PH_DRAIN;
				end else begin
					d_kind    = K_RUN;
					d_idx_a   = rle4 ? {4'd0, hi} : byte_v;
					d_n       = 21'(run_rem_q);
					n_run_rem = '0;
					n_phase   = PH_START;
				end
			end
			PH_ESC: begin
				if (byte_v == ESC_EOL) begin
					if (col_q != '0) begin
						d_kind = K_RUN;
						d_n    = 21'(w_rem);
					end
					n_phase = PH_START;
				end else if (byte_v == ESC_EOI) begin
					d_kind = K_EOI;
				end else if (byte_v == ESC_DELTA) begin
					n_phase = PH_DX;
				end else begin
					n_run_rem = byte_v;
					n_pad     = rle8 ? {1'b0, byte_v[0]} : {1'b0, byte_v[1] ^ byte_v[0]};
					n_phase   = PH_ABS;
				end
			end
			PH_DX: begin
				n_dcol  = byte_v;
				n_phase = PH_DY;
			end
			PH_DY: begin
				d_kind  = K_RUN;
				d_delta = 1'b1;
				d_dy    = byte_v;
				d_n     = 21'(dcol_q) + 21'(byte_v * eff_w);
				n_phase = PH_START;
			end
			PH_ABS: begin
				d_kind = K_PAT;
				if (rle8) begin
					d_idx_a = byte_v;
					if (run_rem_q != 8'd0) begin
						n_run_rem = run_rem_q - 8'd1;
					end
				end else begin
					d_idx_a = {4'd0, hi};
					d_idx_b = {4'd0, lo};
					d_sel   = 8'h02;
					if (run_rem_q >= 8'd2) begin
						d_k       = 4'd2;
						n_run_rem = run_rem_q - 8'd2;
					end else begin
						n_run_rem = '0;
					end
				end
				if (n_run_rem == 8'd0) begin
					n_phase = (pad_q != 2'd0) ? PH_ABSPAD : PH_START;
				end
			end
			PH_ABSPAD: begin
				n_pad   = '0;
				n_phase = PH_START;
			end
			default: begin
				if (!rle8 && !rle4) begin
					d_raw = 1'b1;
					case (depth_q)
						DEPTH_1: begin
							d_kind  = K_PAT;
							d_idx_b = 8'd1;
							for (int j = 0; j < 8; j++) begin
								d_sel[j] = byte_v[7-j];
							end
							d_k = (w_rem > DIM_W'(8)) ? 4'd8 : w_rem[3:0];
						end
						DEPTH_4: begin
							d_kind  = K_PAT;
							d_idx_a = {4'd0, hi};
							d_idx_b = {4'd0, lo};
							d_sel   = 8'h02;
							d_k     = (w_rem >= DIM_W'(2)) ? 4'd2 : 4'd1;
						end
						DEPTH_8: begin
							d_kind  = K_PAT;
							d_idx_a = byte_v;
						end
						default: begin
							// bytes come blue, green, red
							if (slot_q == 2'd0) begin
								n_pbuf = {8'd0, byte_v};
								n_slot = 2'd1;
							end else if (slot_q == 2'd1) begin
								n_pbuf = {byte_v, pbuf_q[7:0]};
								n_slot = 2'd2;
							end else begin
								d_kind   = K_PAT;
								d_direct = 1'b1;
								d_rgb    = {byte_v, pbuf_q};
								n_pbuf   = '0;
								n_slot   = 2'd0;
							end
						end
					endcase
				end else if (byte_v != 8'd0) begin
					n_run_rem = byte_v;
					n_phase   = PH_COLOUR;
				end else begin
					n_phase = PH_ESC;
				end
			end
		endcase
	end

	//------------------------------------------------------------------
	// Clip against the pixels left in the image and advance the position
	//------------------------------------------------------------------
	assign left      = 26'((eff_h - rows_q) * eff_w) - 26'(col_q);
	assign p_n       = (d_kind == K_PAT) ? 21'(d_k) : d_n;
	assign is_put    = ((d_kind == K_PAT) || (d_kind == K_RUN)) && (p_n != '0);
	assign done_now  = is_put && (26'(p_n) >= left);
	assign n_eff     = done_now ? left[20:0] : p_n;
	assign pos_add   = d_delta ? DIM_W'(dcol_q) : n_eff[DIM_W-1:0];
	assign total     = {1'b0, col_q} + {1'b0, pos_add};
	assign rows_base = rows_q + (d_delta ? DIM_W'(d_dy) : DIM_W'(0));
	assign has_res   = proc && ((d_kind == K_EOI) || is_put);

	// one restoring step: compare against width shifted by the step number
	assign div_shift  = 26'(eff_w) << div_cnt_q;
	assign div_ge     = 26'(div_rem_q) >= div_shift;
	assign div_rem_nx = div_ge ? (div_rem_q - div_shift[DIM_W-1:0]) : div_rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			run_rem_q  <= '0;
			run_col_q  <= '0;
			nib_q      <= 1'b0;
			dcol_q     <= '0;
			pad_q      <= '0;
			pbuf_q     <= '0;
			slot_q     <= '0;
			col_q      <= '0;
			rows_q     <= '0;
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
			div_rem_q  <= '0;
		end else if (cfg_we) begin
			// restart decoding, palette kept
			phase_q    <= PH_START;
			run_rem_q  <= '0;
			run_col_q  <= '0;
			nib_q      <= 1'b0;
			dcol_q     <= '0;
			pad_q      <= '0;
			pbuf_q     <= '0;
			slot_q     <= '0;
			col_q      <= '0;
			rows_q     <= '0;
			div_busy_q <= 1'b0;
		end else if (div_busy_q) begin
			div_rem_q <= div_rem_nx;
			if (div_ge) begin
				rows_q <= rows_q + (DIM_W'(1) << div_cnt_q);
			end
			if (div_cnt_q == 4'd0) begin
				div_busy_q <= 1'b0;
				col_q      <= div_rem_nx;
			end else begin
				div_cnt_q <= div_cnt_q - 4'd1;
			end
		end else if (proc) begin
			run_col_q <= n_run_col;
			nib_q     <= n_nib ^ (d_nib_tog & n_eff[0]);
			dcol_q    <= n_dcol;
			pbuf_q    <= n_pbuf;
			slot_q    <= n_slot;
			if (done_now || (d_kind == K_EOI)) begin
				phase_q   <= PH_DONE;
				run_rem_q <= '0;
				pad_q     <= n_pad;
			end else if (d_raw && (total == {1'b0, eff_w}) && (d_rawpad != 2'd0)) begin
				// row finished: skip its padding bytes
				phase_q   <= PH_ROWPAD;
				run_rem_q <= n_run_rem;
				pad_q     <= d_rawpad;
			end else begin
				phase_q   <= n_phase;
				run_rem_q <= n_run_rem;
				pad_q     <= n_pad;
			end
			if (is_put && !done_now) begin
				if (total < {1'b0, eff_w}) begin
					col_q  <= total[DIM_W-1:0];
					rows_q <= rows_base;
				end else if (total < {eff_w, 1'b0}) begin
					col_q  <= DIM_W'(total - {1'b0, eff_w});
					rows_q <= rows_base + DIM_W'(1);
				end else begin
					rows_q     <= rows_base;
					div_rem_q  <= total[DIM_W-1:0];
					div_cnt_q  <= 4'(DIM_W - 1);
					div_busy_q <= 1'b1;
				end
			end
		end
	end

	//------------------------------------------------------------------
	// Palette RAM: write on palette beats, read both colours on every beat
	//------------------------------------------------------------------
	bmpd_ram #(
		.WIDTH(RGB_W),
		.DEPTH(PAL_ENTRIES)
	) u_palette (
		.clk     (clk),
		.we      (pal_we),
		.waddr   (in_item.palette_index[$clog2(PAL_ENTRIES)-1:0]),
		.wdata   ({in_item.palette_red, in_item.palette_green, in_item.palette_blue}),
		.re      (in_acc),
		.raddr_a (d_idx_a[$clog2(PAL_ENTRIES)-1:0]),
		.raddr_b (d_idx_b[$clog2(PAL_ENTRIES)-1:0]),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	//------------------------------------------------------------------
	// Stage 1: plan waits here for the palette data
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc && has_res) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && has_res) begin
			s1_kind   <= d_kind;
			s1_len    <= n_eff[RUN_W-1:0];
			s1_k      <= n_eff[3:0];
			s1_sel    <= d_sel;
			s1_direct <= d_direct;
			s1_rgb    <= d_rgb;
			s1_done   <= done_now || (d_kind == K_EOI);
			s1_blk_a  <= {1'b0, d_idx_a} >= 9'(PAL_ENTRIES);
			s1_blk_b  <= {1'b0, d_idx_b} >= 9'(PAL_ENTRIES);
		end
	end

	// merge neighbors of equal colour into runs
	assign rgb_a = s1_direct ? s1_rgb : (s1_blk_a ? '0 : rd_a);
	assign rgb_b = s1_blk_b ? '0 : rd_b;

	always_comb begin
		logic [2:0] ent [8];
		logic [2:0] e;
		logic       same;
		same = (rgb_a == rgb_b);
		e    = '0;
		for (int j = 0; j < 8; j++) begin
			if ((j > 0) && !same && (s1_sel[j] != s1_sel[j-1])) begin
				e = e + 3'd1;
			end
			ent[j] = e;
		end
		for (int m = 0; m < 8; m++) begin
			m_len[m] = '0;
			m_rgb[m] = (s1_sel[0] ^ m[0]) ? rgb_b : rgb_a;
			for (int j = 0; j < 8; j++) begin
				if ((4'(j) < s1_k) && (ent[j] == 3'(m))) begin
					m_len[m] = m_len[m] + RUN_W'(1);
				end
			end
		end
		m_cnt = {1'b0, ent[3'(s1_k - 4'd1)]} + 4'd1;
		case (s1_kind)
			K_RUN: begin
				m_cnt    = 4'd1;
				m_rgb[0] = rgb_a;
				m_len[0] = s1_len;
			end
			K_EOI: begin
				m_cnt    = 4'd1;
				m_rgb[0] = '0;
				m_len[0] = '0;
			end
			default: begin
				m_cnt = m_cnt;
			end
		endcase
	end

	//------------------------------------------------------------------
	// Output buffer: runs of one input beat; unless out_stall holds them, sent one per cycle
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= '0;
			buf_idx_q <= '0;
		end else if (s1_adv) begin
			buf_cnt_q <= m_cnt;
			buf_idx_q <= '0;
		end else if (out_take) begin
			if (out_last) begin
				buf_cnt_q <= '0;
				buf_idx_q <= '0;
			end else begin
				buf_idx_q <= buf_idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			buf_rgb_q  <= m_rgb;
			buf_len_q  <= m_len;
			buf_done_q <= s1_done;
		end
	end

	assign out_item.red        = buf_rgb_q[buf_idx_q][23:16];
	assign out_item.green      = buf_rgb_q[buf_idx_q][15:8];
	assign out_item.blue       = buf_rgb_q[buf_idx_q][7:0];
	assign out_item.run_length = buf_len_q[buf_idx_q];
	assign out_item.last       = out_last;
	assign out_item.image_done = out_last && buf_done_q;

`ifndef SYNTH
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, buf_idx_q} < buf_cnt_q))
		else $error("output buffer index past its fill");

	a_div_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q |-> in_stall)
		else $error("input taken while the position divider runs");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !buf_free) |=> s1_valid_q)
		else $error("stage 1 plan lost while the buffer was full");

	a_div_ends_below_width: assert property (@(posedge clk) disable iff (!arst_n)
		(div_busy_q && (div_cnt_q == 4'd0) && !cfg_we) |=> (col_q < eff_w))
		else $error("divider left a column past the row end");
`endif
endmodule
